### rtl/qpr_pkg.sv
// shared types, constants and arithmetic helpers for the quaternion product / rotate unit
package qpr_pkg;

  localparam int DW        = 32;
  localparam int FRAC_BITS = 28;
  localparam int REQ_W     = 3;
  localparam int PROD_W    = 2 * DW;
  // a term is a (possibly negated, possibly doubled) product shifted down, with sign
  localparam int TERM_W    = PROD_W + 1 - (FRAC_BITS - 1);
  // room for four terms added exactly
  localparam int SUM_W     = TERM_W + 2;
  localparam int NUM_LANES = 16;
  localparam int NUM_COEF  = 9;

  localparam logic [REQ_W-1:0] REQ_PRODUCT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CONJ_L  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CONJ_R  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ROT_B2I = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ROT_I2B = 3'd4;

  typedef logic signed [DW-1:0]     word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef word_t quat_t [4];
  typedef word_t vec_t [3];
  typedef word_t coef_t [NUM_COEF];

  // per-pair clock enables of a multiply stage and the add stage behind it
  typedef struct packed {
    logic mul;
    logic add;
  } pipe_en_t;

  localparam word_t SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // hamilton product lanes, four per output row (s, x, y, z)
  localparam logic [1:0] PROD_A [NUM_LANES] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] PROD_B [NUM_LANES] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic PROD_NEG [NUM_LANES] = '{
    1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  // rotation lanes: squares, then the six cross products of the left quaternion
  localparam int LN_SS = 0;
  localparam int LN_XX = 1;
  localparam int LN_YY = 2;
  localparam int LN_ZZ = 3;
  localparam int LN_XY = 4;
  localparam int LN_SZ = 5;
  localparam int LN_SY = 6;
  localparam int LN_XZ = 7;
  localparam int LN_YZ = 8;
  localparam int LN_SX = 9;
  localparam logic [1:0] ROT_A [NUM_LANES] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] ROT_B [NUM_LANES] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd2, 2'd3,
    2'd3, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};

  // floor(+-(dbl ? 2 : 1) * p / 2^FRAC_BITS), negation done before the shift
  function automatic term_t fx_term(input prod_t p, input logic neg, input logic dbl);
    logic signed [PROD_W:0] e;
    logic signed [PROD_W:0] sh;
    e = {p[PROD_W-1], p};
    if (neg) begin
      e = -e;
    end
    sh = dbl ? (e >>> (FRAC_BITS - 1)) : (e >>> FRAC_BITS);
    return sh[TERM_W-1:0];
  endfunction

  function automatic sum_t fx_ext(input term_t t);
    return {{(SUM_W-TERM_W){t[TERM_W-1]}}, t};
  endfunction

  function automatic word_t fx_sat(input sum_t v);
    logic [SUM_W-DW:0] hi;
    hi = v[SUM_W-1:DW-1];
    if ((&hi) || !(|hi)) begin
      return v[DW-1:0];
    end else if (v[SUM_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

### rtl/qpr_if.sv
// valid/ready channel interfaces for request and result words
interface qpr_req_if;
  import qpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  word_t            left_s;
  word_t            left_x;
  word_t            left_y;
  word_t            left_z;
  word_t            right_s;
  word_t            right_x;
  word_t            right_y;
  word_t            right_z;
  modport source (output valid, req_type, left_s, left_x, left_y, left_z,
                  right_s, right_x, right_y, right_z, input ready);
  modport sink (input valid, req_type, left_s, left_x, left_y, left_z,
                right_s, right_x, right_y, right_z, output ready);
endinterface

interface qpr_res_if;
  import qpr_pkg::*;
  logic  valid;
  logic  ready;
  word_t out_s;
  word_t out_x;
  word_t out_y;
  word_t out_z;
  modport source (output valid, out_s, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_s, out_x, out_y, out_z, output ready);
endinterface

### rtl/qpr_front.sv
// first multiply stage and the product / rotation-coefficient sum stage
module qpr_front (
  input  logic                        clk,
  input  qpr_pkg::pipe_en_t           en,
  input  logic [qpr_pkg::REQ_W-1:0]   req_type,
  input  qpr_pkg::quat_t              left,
  input  qpr_pkg::quat_t              right,
  output logic [qpr_pkg::REQ_W-1:0]   req2,
  output qpr_pkg::vec_t               vec2,
  output qpr_pkg::coef_t              w2
);
  import qpr_pkg::*;

  logic [REQ_W-1:0] req1;
  prod_t            p1 [NUM_LANES];
  vec_t             vec1;
  word_t            opa [NUM_LANES];
  word_t            opb [NUM_LANES];
  word_t            prod_out [4];
  coef_t            coef;
  logic             rot_in;
  logic             rot1;
  logic             conj_l;
  logic             conj_r;

  assign rot_in = (req_type == REQ_ROT_B2I) || (req_type == REQ_ROT_I2B);

  // operand routing per lane
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (rot_in) begin
        opa[l] = left[ROT_A[l]];
        opb[l] = left[ROT_B[l]];
      end else begin
        opa[l] = left[PROD_A[l]];
        opb[l] = right[PROD_B[l]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      req1 <= req_type;
      for (int l = 0; l < NUM_LANES; l++) begin
        p1[l] <= opa[l] * opb[l];
      end
      for (int j = 0; j < 3; j++) begin
        vec1[j] <= right[j+1];
      end
    end
  end

  assign rot1   = (req1 == REQ_ROT_B2I) || (req1 == REQ_ROT_I2B);
  assign conj_l = (req1 == REQ_CONJ_L);
  assign conj_r = (req1 == REQ_CONJ_R);

  // hamilton product rows with conjugation folded into the term signs
  always_comb begin : prod_sum
    sum_t acc;
    logic neg;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        neg = PROD_NEG[4*r+k] ^ (conj_l && (PROD_A[4*r+k] != 2'd0))
                              ^ (conj_r && (PROD_B[4*r+k] != 2'd0));
        acc = acc + fx_ext(fx_term(p1[4*r+k], neg, 1'b0));
      end
      prod_out[r] = fx_sat(acc);
    end
  end

  // rotation matrix, row-major
  always_comb begin
    coef[0] = fx_sat(fx_ext(fx_term(p1[LN_SS], 1'b0, 1'b0)) + fx_ext(fx_term(p1[LN_XX], 1'b0, 1'b0))
                   + fx_ext(fx_term(p1[LN_YY], 1'b1, 1'b0)) + fx_ext(fx_term(p1[LN_ZZ], 1'b1, 1'b0)));
    coef[4] = fx_sat(fx_ext(fx_term(p1[LN_SS], 1'b0, 1'b0)) + fx_ext(fx_term(p1[LN_XX], 1'b1, 1'b0))
                   + fx_ext(fx_term(p1[LN_YY], 1'b0, 1'b0)) + fx_ext(fx_term(p1[LN_ZZ], 1'b1, 1'b0)));
    coef[8] = fx_sat(fx_ext(fx_term(p1[LN_SS], 1'b0, 1'b0)) + fx_ext(fx_term(p1[LN_XX], 1'b1, 1'b0))
                   + fx_ext(fx_term(p1[LN_YY], 1'b1, 1'b0)) + fx_ext(fx_term(p1[LN_ZZ], 1'b0, 1'b0)));
    coef[1] = fx_sat(fx_ext(fx_term(p1[LN_XY], 1'b0, 1'b1)) + fx_ext(fx_term(p1[LN_SZ], 1'b1, 1'b1)));
    coef[2] = fx_sat(fx_ext(fx_term(p1[LN_SY], 1'b0, 1'b1)) + fx_ext(fx_term(p1[LN_XZ], 1'b0, 1'b1)));
    coef[3] = fx_sat(fx_ext(fx_term(p1[LN_SZ], 1'b0, 1'b1)) + fx_ext(fx_term(p1[LN_XY], 1'b0, 1'b1)));
    coef[5] = fx_sat(fx_ext(fx_term(p1[LN_YZ], 1'b0, 1'b1)) + fx_ext(fx_term(p1[LN_SX], 1'b1, 1'b1)));
    coef[6] = fx_sat(fx_ext(fx_term(p1[LN_XZ], 1'b0, 1'b1)) + fx_ext(fx_term(p1[LN_SY], 1'b1, 1'b1)));
    coef[7] = fx_sat(fx_ext(fx_term(p1[LN_SX], 1'b0, 1'b1)) + fx_ext(fx_term(p1[LN_YZ], 1'b0, 1'b1)));
  end

  always_ff @(posedge clk) begin
    if (en.add) begin
      req2 <= req1;
      vec2 <= vec1;
      for (int i = 0; i < NUM_COEF; i++) begin
        if (rot1 || (i >= 4)) begin
          w2[i] <= coef[i];
        end else begin
          w2[i] <= prod_out[i];
        end
      end
    end
  end

endmodule

### rtl/qpr_back.sv
// matrix-vector multiply stage and the output sum / select register
module qpr_back (
  input  logic                        clk,
  input  qpr_pkg::pipe_en_t           en,
  input  logic [qpr_pkg::REQ_W-1:0]   req2,
  input  qpr_pkg::vec_t               vec2,
  input  qpr_pkg::coef_t              w2,
  output qpr_pkg::quat_t              out_q
);
  import qpr_pkg::*;

  logic [REQ_W-1:0] req3;
  prod_t            p3 [NUM_COEF];
  word_t            pw3 [4];
  word_t            cf [NUM_COEF];
  word_t            rot_out [3];
  logic             transpose;

  assign transpose = (req2 == REQ_ROT_I2B);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cf[3*i+j] = transpose ? w2[3*j+i] : w2[3*i+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      req3 <= req2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p3[3*i+j] <= cf[3*i+j] * vec2[j];
        end
      end
      for (int r = 0; r < 4; r++) begin
        pw3[r] <= w2[r];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot_out[i] = fx_sat(fx_ext(fx_term(p3[3*i], 1'b0, 1'b0))
                        + fx_ext(fx_term(p3[3*i+1], 1'b0, 1'b0))
                        + fx_ext(fx_term(p3[3*i+2], 1'b0, 1'b0)));
    end
  end

  always_ff @(posedge clk) begin
    if (en.add) begin
      unique case (req3) inside
        REQ_PRODUCT, REQ_CONJ_L, REQ_CONJ_R: begin
          out_q <= pw3;
        end
        REQ_ROT_B2I, REQ_ROT_I2B: begin
          out_q[0] <= '0;
          out_q[1] <= rot_out[0];
          out_q[2] <= rot_out[1];
          out_q[3] <= rot_out[2];
        end
        default: begin
          out_q <= '{default: '0};
        end
      endcase
    end
  end

endmodule

### rtl/quaternion_product_rotate_unit.sv
// top level of the fixed-point quaternion product / vector rotation unit
// Four-stage pipeline, one request word accepted per clock and one result word per request;
// stage 1 holds sixteen 32x32 multipliers (quaternion product terms or the squares and cross
// products of the left quaternion), stage 2 adds and saturates them into product components or
// the nine rotation coefficients, stage 3 holds nine 32x32 multipliers for the matrix-vector
// product, and stage 4 is the output register that adds, saturates and selects the result. Each
// stage moves forward whenever the stage behind it is empty or moving, so bubbles close up and a
// waiting result does not stop new requests from entering until all four stages are full.
module quaternion_product_rotate_unit (
  input logic      clk,
  input logic      rst,
  qpr_req_if.sink  req,
  qpr_res_if.source res
);
  import qpr_pkg::*;

  // stage valid bits
  logic     v1;
  logic     v2;
  logic     v3;
  logic     v4;
  logic     en1;
  logic     en2;
  logic     en3;
  logic     en4;
  pipe_en_t front_en;
  pipe_en_t back_en;

  quat_t            left_q;
  quat_t            right_q;
  logic [REQ_W-1:0] req2;
  vec_t             vec2;
  coef_t            w2;
  quat_t            out_q;

  // a stage loads when it is empty or its word moves on this cycle
  assign en4 = !v4 || res.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign req.ready = en1;
  assign res.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= req.valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
    end
  end

  assign front_en = '{mul: en1, add: en2};
  assign back_en  = '{mul: en3, add: en4};

  // component order is s, x, y, z
  assign left_q[0]  = req.left_s;
  assign left_q[1]  = req.left_x;
  assign left_q[2]  = req.left_y;
  assign left_q[3]  = req.left_z;
  assign right_q[0] = req.right_s;
  assign right_q[1] = req.right_x;
  assign right_q[2] = req.right_y;
  assign right_q[3] = req.right_z;

  // stages 1 and 2: product terms or rotation coefficients
  qpr_front u_front (
    .clk      (clk),
    .en       (front_en),
    .req_type (req.req_type),
    .left     (left_q),
    .right    (right_q),
    .req2     (req2),
    .vec2     (vec2),
    .w2       (w2)
  );

  // stages 3 and 4: matrix times vector, output select
  qpr_back u_back (
    .clk   (clk),
    .en    (back_en),
    .req2  (req2),
    .vec2  (vec2),
    .w2    (w2),
    .out_q (out_q)
  );

  assign res.out_s = out_q[0];
  assign res.out_x = out_q[1];
  assign res.out_y = out_q[2];
  assign res.out_z = out_q[3];

  // words in flight change only by what enters and what leaves
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones({v1, v2, v3, v4}) ==
      $countones({$past(v1), $past(v2), $past(v3), $past(v4)})
      + int'($past(req.valid && req.ready)) - int'($past(res.valid && res.ready))))
    else $error("pipeline occupancy mismatch");

  // a word behind a stalled output must not be dropped
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (v3 && v4 && !res.ready) |=> v3)
    else $error("stage 3 word lost during output stall");

  // intake only closes when every stage holds a word and the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v1 && v2 && v3 && v4 && !res.ready))
    else $error("intake blocked with room in the pipeline");

endmodule
